// ===== rtl/bbt_pkg.sv =====
// bbt_pkg: action codes, config constants and the cell control type for
// the bounded bag table. No dependencies.
`default_nettype none
package bbt_pkg;

  localparam int ACT_W = 3;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FIRST  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_NEXT   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd5;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] MAX_ITEMS_RESET = 5'd16;

  typedef struct packed {
    logic rotate;  // every cell takes its right neighbor
    logic shift;   // compaction: only cells at or above the hole move
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/bbt_cell.sv =====
// bbt_cell: one entry (key and data) of the bag chain.
// Depends on bbt_pkg for cell_ctrl_t.
`default_nettype none
module bbt_cell #(
  parameter int IDX       = 0,
  parameter int KEY_BITS  = 16,
  parameter int DATA_BITS = 32,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5
) (
  input  wire logic                  clk,
  input  wire bbt_pkg::cell_ctrl_t   ctrl,
  input  wire logic [IDX_W-1:0]      hole,
  input  wire logic [CNT_W-1:0]      cnt,
  input  wire logic [KEY_BITS-1:0]   src_key,
  input  wire logic [DATA_BITS-1:0]  src_data,
  output logic      [KEY_BITS-1:0]   key_q,
  output logic      [DATA_BITS-1:0]  data_q
);

  logic [KEY_BITS-1:0]  key_r;
  logic [DATA_BITS-1:0] data_r;
  logic                 load;

  // compaction moves cells from the hole up to the last held entry minus one
  assign load = ctrl.rotate
              | (ctrl.shift && (IDX >= int'(hole)) && ((IDX + 1) < int'(cnt)));

  always_ff @(posedge clk) begin
    if (load) begin
      key_r  <= src_key;
      data_r <= src_data;
    end
  end

  assign key_q  = key_r;
  assign data_q = data_r;

endmodule
`default_nettype wire

// ===== rtl/bounded_bag_table_unit.sv =====
// bounded_bag_table_unit: bounded bag of key/data entries in a ring of cells.
// Each command walks the whole ring, then a finish state registers the result;
// a remove that hits passes through a shift state before the finish state.
// A new command is accepted only while busy is low, once the last one ends.
// Reset (rst_n low, synchronous): empty bag, cursor -1, max_items 16.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
module bounded_bag_table_unit #(
  parameter int DEPTH     = 16,
  parameter int KEY_BITS  = 16,
  parameter int DATA_BITS = 32,
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W    = $clog2(DEPTH + 1),
  localparam int CUR_W    = $clog2(DEPTH) + 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // command channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [bbt_pkg::ACT_W-1:0]    in_action,
  input  wire logic [KEY_BITS-1:0]          in_key,
  input  wire logic [DATA_BITS-1:0]         in_entry_data,
  // result channel
  output logic                              out_valid,
  output logic                              out_ok,
  output logic      [KEY_BITS-1:0]          out_key,
  output logic      [DATA_BITS-1:0]         out_data,
  output logic      [CNT_W-1:0]             out_count,
  // config
  input  wire logic                         cfg_we,
  input  wire logic [bbt_pkg::CFG_W-1:0]    cfg_data
);

  // Sequencer: every command walks the ring once (DEPTH steps). At step t
  // cell 0 holds entry t; it is fed back into the last cell, so after DEPTH
  // steps the ring is back in order. Insert swaps the fed-back word for the
  // new entry at step t == count. A remove that hits then passes through a
  // shift state: cells from the hole to count - 2 take their right neighbor.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROT   = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [IDX_W-1:0]            step_r, step_nxt;
  logic [bbt_pkg::ACT_W-1:0]   act_r;
  logic [KEY_BITS-1:0]         key_r;
  logic [DATA_BITS-1:0]        data_r;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [CUR_W-1:0]            cursor_r, cursor_nxt;   // two's complement, -1 at reset
  logic [bbt_pkg::CFG_W-1:0]   max_items_r;

  // per-command scratch
  logic                        found_r, found_nxt;
  logic [IDX_W-1:0]            hole_r, hole_nxt;
  logic [KEY_BITS-1:0]         res_key_r, res_key_nxt;
  logic [DATA_BITS-1:0]        res_data_r, res_data_nxt;

  // result registers
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_ok_r, out_ok_nxt;
  logic [KEY_BITS-1:0]         out_key_r, out_key_nxt;
  logic [DATA_BITS-1:0]        out_data_r, out_data_nxt;

  // ring
  logic [KEY_BITS-1:0]         cell_key  [DEPTH];
  logic [DATA_BITS-1:0]        cell_data [DEPTH];
  logic [KEY_BITS-1:0]         feed_key;
  logic [DATA_BITS-1:0]        feed_data;
  bbt_pkg::cell_ctrl_t         ctrl;

  logic                        accept;
  logic                        last_step;
  logic [CUR_W-1:0]            t_ext, cnt_ext, tgt;
  logic                        ins_ok, cnt_nz, next_ok, hit;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign last_step = (step_r == IDX_W'(DEPTH - 1));

  assign t_ext   = CUR_W'(step_r);
  assign cnt_ext = CUR_W'(count_r);
  assign tgt     = cursor_r + CUR_W'(1);          // -1 wraps to entry 0
  assign cnt_nz  = (count_r != '0);
  assign next_ok = cnt_nz && (tgt < cnt_ext);
  // capacity in use is max_items clamped to the built depth
  assign ins_ok  = (32'(count_r) < 32'(max_items_r)) && (32'(count_r) < 32'(DEPTH));
  assign hit     = (t_ext < cnt_ext) && (cell_key[0] == key_r);

  assign ctrl.rotate = (state_r == ST_ROT);
  assign ctrl.shift  = (state_r == ST_SHIFT);

  // word going back into the tail of the ring
  always_comb begin
    feed_key  = cell_key[0];
    feed_data = cell_data[0];
    if (act_r == bbt_pkg::ACT_INSERT && ins_ok && t_ext == cnt_ext) begin
      feed_key  = key_r;
      feed_data = data_r;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [KEY_BITS-1:0]  src_key;
      logic [DATA_BITS-1:0] src_data;
      if (gi == DEPTH - 1) begin : g_tail
        assign src_key  = feed_key;
        assign src_data = feed_data;
      end else begin : g_body
        assign src_key  = cell_key[gi+1];
        assign src_data = cell_data[gi+1];
      end
      bbt_cell #(
        .IDX       (gi),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
      ) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .hole     (hole_r),
        .cnt      (count_r),
        .src_key  (src_key),
        .src_data (src_data),
        .key_q    (cell_key[gi]),
        .data_q   (cell_data[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    found_nxt     = found_r;
    hole_nxt      = hole_r;
    res_key_nxt   = res_key_r;
    res_data_nxt  = res_data_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_key_nxt   = out_key_r;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt    = ST_ROT;
          step_nxt     = '0;
          found_nxt    = 1'b0;
          hole_nxt     = '0;
          res_key_nxt  = '0;
          res_data_nxt = '0;
        end
      end
      ST_ROT: begin
        // capture from the head of the ring
        case (act_r)
          bbt_pkg::ACT_QUERY, bbt_pkg::ACT_REMOVE: begin
            if (hit && !found_r) begin
              found_nxt    = 1'b1;
              hole_nxt     = step_r;
              res_key_nxt  = cell_key[0];
              res_data_nxt = cell_data[0];
            end
          end
          bbt_pkg::ACT_FIRST: begin
            if (cnt_nz && step_r == '0) begin
              res_key_nxt  = cell_key[0];
              res_data_nxt = cell_data[0];
            end
          end
          bbt_pkg::ACT_NEXT: begin
            if (next_ok && t_ext == tgt) begin
              res_key_nxt  = cell_key[0];
              res_data_nxt = cell_data[0];
            end
          end
          default: ;
        endcase
        step_nxt = step_r + IDX_W'(1);
        if (last_step) begin
          step_nxt  = '0;
          state_nxt = (act_r == bbt_pkg::ACT_REMOVE && found_nxt) ? ST_SHIFT : ST_FIN;
        end
      end
      ST_SHIFT: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_key_nxt   = res_key_r;
        out_data_nxt  = res_data_r;
        out_ok_nxt    = 1'b0;
        case (act_r)
          bbt_pkg::ACT_INSERT: begin
            out_ok_nxt = ins_ok;
            if (ins_ok) count_nxt = count_r + CNT_W'(1);
          end
          bbt_pkg::ACT_QUERY: out_ok_nxt = found_r;
          bbt_pkg::ACT_REMOVE: begin
            out_ok_nxt = found_r;
            if (found_r) count_nxt = count_r - CNT_W'(1);
          end
          bbt_pkg::ACT_FIRST: begin
            out_ok_nxt = cnt_nz;
            if (cnt_nz) cursor_nxt = '0;
          end
          bbt_pkg::ACT_NEXT: begin
            out_ok_nxt = next_ok;
            if (next_ok) cursor_nxt = tgt;
          end
          bbt_pkg::ACT_CLEAR: begin
            out_ok_nxt = 1'b1;
            count_nxt  = '0;
          end
          default: ;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      cursor_r    <= '1;
      max_items_r <= bbt_pkg::MAX_ITEMS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) max_items_r <= cfg_data;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_action;
      key_r  <= in_key;
      data_r <= in_entry_data;
    end
    found_r    <= found_nxt;
    hole_r     <= hole_nxt;
    res_key_r  <= res_key_nxt;
    res_data_r <= res_data_nxt;
    out_ok_r   <= out_ok_nxt;
    out_key_r  <= out_key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_key   = out_key_r;
  assign out_data  = out_data_r;
  assign out_count = count_r;

  // checks
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a command in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(out_count) <= 32'(DEPTH))
    else $error("entry count above built depth");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_key == '0 && out_data == '0))
    else $error("failed beat carries nonzero entry");

endmodule
`default_nettype wire

// ===== dv/tb_bounded_bag_table_unit.sv =====
// Self-checking testbench for bounded_bag_table_unit: directed and random
// table operations, checked against an in-bench predictor of the bag.
// Depends on rtl/bbt_pkg.sv and rtl/bounded_bag_table_unit.sv.
module tb_bounded_bag_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BAG_DEPTH = 16;
  localparam int KEY_W     = 16;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 5;
  localparam int RUN_LIMIT = 200000;    // cycles; slowest clean run is well under this
  localparam int TAIL_WAIT = BAG_DEPTH + 6;

  // action codes the block ignores
  localparam logic [bbt_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [bbt_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic              ok;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
  } bag_reply_t;

  // ---------------------------------------------------------------------------
  // DUT ports; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [bbt_pkg::ACT_W-1:0]    in_action = bbt_pkg::ACT_CLEAR;
  logic [KEY_W-1:0]             in_key = '0;
  logic [DATA_W-1:0]            in_entry_data = '0;
  logic                         out_valid;
  logic                         out_ok;
  logic [KEY_W-1:0]             out_key;
  logic [DATA_W-1:0]            out_data;
  logic [CNT_W-1:0]             out_count;
  logic                         cfg_we = 1'b0;
  logic [bbt_pkg::CFG_W-1:0]    cfg_data = bbt_pkg::MAX_ITEMS_RESET;

  bounded_bag_table_unit #(
    .DEPTH    (BAG_DEPTH),
    .KEY_BITS (KEY_W),
    .DATA_BITS(DATA_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_key       (in_key),
    .in_entry_data(in_entry_data),
    .out_valid    (out_valid),
    .out_ok       (out_ok),
    .out_key      (out_key),
    .out_data     (out_data),
    .out_count    (out_count),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predicted bag: its own copy of the table, cursor and capacity register
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]          held_keys [BAG_DEPTH];
  logic [DATA_W-1:0]         held_data [BAG_DEPTH];
  int                        held = 0;          // entries in the bag
  int                        walk_pos = -1;     // get-first/get-next cursor, -1 after reset
  logic [bbt_pkg::CFG_W-1:0] cap_setting = bbt_pkg::MAX_ITEMS_RESET;

  bag_reply_t        awaited_replies[$];  // one per accepted beat, oldest first
  int                mismatches = 0;
  int                cycle_count = 0;
  bit                gaps_on = 1'b1;     // sender idles between beats when set
  logic [KEY_W-1:0]  key_pool [6];       // small key set so lookups hit and keys repeat

  // Applies one accepted beat to the predicted bag and queues the reply it owes.
  task automatic predict_bag_op(input logic [bbt_pkg::ACT_W-1:0] act,
                                input logic [KEY_W-1:0] key,
                                input logic [DATA_W-1:0] data);
    bag_reply_t r;
    int         lim;
    int         hit;
    r   = '0;
    // a setting above the built depth acts as the depth; zero refuses all inserts
    lim = (int'(cap_setting) > BAG_DEPTH) ? BAG_DEPTH : int'(cap_setting);
    hit = -1;
    for (int i = held - 1; i >= 0; i--)
      if (held_keys[i] == key) hit = i;   // lowest index wins
    case (act)
      bbt_pkg::ACT_INSERT: begin
        // no entry comes back on insert; refused once the count reaches the limit
        if (held < lim) begin
          held_keys[held] = key;
          held_data[held] = data;
          held++;
          r.ok = 1'b1;
        end
      end
      bbt_pkg::ACT_QUERY, bbt_pkg::ACT_REMOVE: begin
        if (hit >= 0) begin
          r.ok   = 1'b1;
          r.key  = held_keys[hit];
          r.data = held_data[hit];
          if (act == bbt_pkg::ACT_REMOVE) begin
            // compaction: later entries slide down one slot, cursor untouched
            for (int j = hit; j + 1 < held; j++) begin
              held_keys[j] = held_keys[j+1];
              held_data[j] = held_data[j+1];
            end
            held--;
          end
        end
      end
      bbt_pkg::ACT_FIRST: begin
        if (held > 0) begin
          walk_pos = 0;
          r.ok     = 1'b1;
          r.key    = held_keys[0];
          r.data   = held_data[0];
        end
      end
      bbt_pkg::ACT_NEXT: begin
        // a cursor at -1 steps onto entry 0; at or past the last entry it stays
        if (held > 0 && walk_pos < held - 1) begin
          walk_pos++;
          r.ok   = 1'b1;
          r.key  = held_keys[walk_pos];
          r.data = held_data[walk_pos];
        end
      end
      bbt_pkg::ACT_CLEAR: begin
        held = 0;
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.count = held[CNT_W-1:0];
    awaited_replies.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Mostly no gap, some short, a few long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    return $urandom_range(12, 48);
  endfunction

  // Presents one beat and holds it until the edge that takes it. start is left
  // high so back-to-back beats never drop and raise it in one step.
  task automatic send_op(input logic [bbt_pkg::ACT_W-1:0] act,
                         input logic [KEY_W-1:0] key,
                         input logic [DATA_W-1:0] data);
    int unsigned idle;
    in_action     <= act;
    in_key        <= key;
    in_entry_data <= data;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    predict_bag_op(act, key, data);
    idle = gaps_on ? gap_len() : 0;
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // Holds off until every owed reply is in and the block has gone idle.
  task automatic drain_bag();
    start <= 1'b0;
    do @(posedge clk); while (busy || awaited_replies.size() != 0);
  endtask

  // Capacity is only changed with the block idle.
  task automatic write_max_items(input logic [bbt_pkg::CFG_W-1:0] value);
    drain_bag();
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cap_setting = value;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Reply checker: each strobed beat against the oldest owed reply
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_replies
    bag_reply_t want;
    if (rst_n && out_valid) begin
      if (awaited_replies.size() == 0) begin
        $error("reply beat with nothing owed: ok=%0d key=%h data=%h count=%0d",
               out_ok, out_key, out_data, out_count);
        mismatches++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_ok);
          mismatches++;
        end
        if (out_key !== want.key) begin
          $error("out_key: expected %h, got %h", want.key, out_key);
          mismatches++;
        end
        if (out_data !== want.data) begin
          $error("out_data: expected %h, got %h", want.data, out_data);
          mismatches++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  // Every lookup and walk on a fresh, empty bag misses; spare codes do nothing.
  task automatic test_empty_bag();
    send_op(bbt_pkg::ACT_FIRST,  16'h0000, 32'h0);
    send_op(bbt_pkg::ACT_NEXT,   16'h0000, 32'h0);   // cursor still -1, bag empty
    send_op(bbt_pkg::ACT_QUERY,  16'hFFFF, 32'h0);
    send_op(bbt_pkg::ACT_REMOVE, 16'h0000, 32'h0);
    send_op(ACT_SPARE_LO,        16'hFFFF, 32'hFFFF_FFFF);
    send_op(ACT_SPARE_HI,        16'h5A5A, 32'hA5A5_A5A5);
  endtask

  // Field extremes, a repeated key, then an insert into a full bag.
  task automatic test_insert_to_full();
    write_max_items(5'd3);
    send_op(bbt_pkg::ACT_INSERT, 16'h0000, 32'h0000_0000);
    send_op(bbt_pkg::ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(bbt_pkg::ACT_INSERT, 16'hFFFF, 32'h1234_5678);
    send_op(bbt_pkg::ACT_INSERT, 16'h7E81, 32'h8000_0001);   // refused, bag full
  endtask

  // Walk the bag and step off the end.
  task automatic test_cursor_walk();
    send_op(bbt_pkg::ACT_FIRST, 16'h0, 32'h0);
    send_op(bbt_pkg::ACT_NEXT,  16'h0, 32'h0);
    send_op(bbt_pkg::ACT_NEXT,  16'h0, 32'h0);
    send_op(bbt_pkg::ACT_NEXT,  16'h0, 32'h0);   // past the end, cursor holds
  endtask

  // First match wins on a repeated key; removing the head compacts the rest.
  task automatic test_lookup_and_remove();
    send_op(bbt_pkg::ACT_QUERY,  16'hFFFF, 32'h0);
    send_op(bbt_pkg::ACT_REMOVE, 16'h0000, 32'h0);
    send_op(bbt_pkg::ACT_QUERY,  16'h0000, 32'h0);   // gone now
    send_op(bbt_pkg::ACT_NEXT,   16'h0,    32'h0);   // cursor left beyond the new end
  endtask

  // Capacity below the count, zero, and above the built depth.
  task automatic test_capacity_edges();
    write_max_items(5'd1);
    send_op(bbt_pkg::ACT_INSERT, 16'h1111, 32'h2222_2222);   // entries kept, insert refused
    write_max_items(5'd0);
    send_op(bbt_pkg::ACT_INSERT, 16'h3333, 32'h4444_4444);   // zero refuses everything
    write_max_items(5'd31);
    send_op(bbt_pkg::ACT_INSERT, 16'h5555, 32'h6666_6666);   // acts as full depth
    send_op(bbt_pkg::ACT_REMOVE, 16'hFFFF, 32'h0);
  endtask

  // Clear always succeeds and leaves the cursor; the walk then misses.
  task automatic test_clear();
    send_op(bbt_pkg::ACT_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(bbt_pkg::ACT_NEXT,  16'h0,    32'h0);
    send_op(bbt_pkg::ACT_FIRST, 16'h0,    32'h0);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------
  function automatic logic [bbt_pkg::ACT_W-1:0] pick_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 38) return bbt_pkg::ACT_INSERT;
    if (r < 56) return bbt_pkg::ACT_QUERY;
    if (r < 72) return bbt_pkg::ACT_REMOVE;
    if (r < 79) return bbt_pkg::ACT_FIRST;
    if (r < 93) return bbt_pkg::ACT_NEXT;
    if (r < 95) return bbt_pkg::ACT_CLEAR;
    if (r < 97) return ACT_SPARE_LO;
    return ACT_SPARE_HI;
  endfunction

  // Keys mostly from the bag or the pool so lookups hit and duplicates build up.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40 && held > 0) return held_keys[$urandom_range(0, held - 1)];
    if (r < 85) return key_pool[$urandom_range(0, 5)];
    return KEY_W'($urandom());
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 16) return '1;
    return DATA_W'($urandom());
  endfunction

  // Phases at different capacities; some run back to back with no idling.
  task automatic test_random_traffic();
    logic [bbt_pkg::CFG_W-1:0] caps [8];
    logic [bbt_pkg::ACT_W-1:0] act;
    caps[0] = 5'd16;
    caps[1] = 5'd31;
    caps[2] = 5'd1;
    caps[3] = 5'd0;
    caps[4] = 5'd4;
    caps[5] = bbt_pkg::CFG_W'($urandom_range(1, 16));
    caps[6] = bbt_pkg::CFG_W'($urandom_range(17, 31));
    caps[7] = 5'd16;
    for (int p = 0; p < 8; p++) begin
      write_max_items(caps[p]);
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int k = 2; k < 6; k++) key_pool[k] = KEY_W'($urandom());
      gaps_on = (p % 3 != 1);
      for (int n = 0; n < 64; n++) begin
        // now and then let the pipe run dry before the next beat
        if ($urandom_range(0, 39) == 0) drain_bag();
        act = pick_action();
        send_op(act, pick_key(), pick_data());
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_bag();
    test_insert_to_full();
    test_cursor_walk();
    test_lookup_and_remove();
    test_capacity_edges();
    test_clear();
    test_random_traffic();

    drain_bag();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
